/* hdl/hsc_pkg.sv */
// package for the heap sort block: sizes, command codes and payload types
// no dependencies
`default_nettype none
package hsc_pkg;
    localparam int MAX_ELEMENTS = 1024;
    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int CMP_MAX = 65535;
    localparam int COPY_MAX = 131071;
    localparam int COPIES_PER_SWAP = 3;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SORT = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_ELEMENT = 1'b1;

    typedef struct packed {
        logic [1:0] mode;
        logic signed [31:0] value;
        logic [9:0] index;
    } cmd_t;

    typedef struct packed {
        logic result_kind;
        logic signed [31:0] element;
        logic in_range;
        logic [15:0] comparisons;
        logic [16:0] copies;
        logic [10:0] length;
    } rsp_t;
endpackage
`default_nettype wire

/* hdl/hsc_cmd_if.sv */
// handshake channel for commands
// depends on hsc_pkg
`default_nettype none
interface hsc_cmd_if;
    logic valid;
    logic ready;
    hsc_pkg::cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/hsc_rsp_if.sv */
// result channel
// depends on hsc_pkg
`default_nettype none
interface hsc_rsp_if;
    logic valid;
    logic ready;
    hsc_pkg::rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/heap_sort_with_counts.sv */
// heap sort engine: top level with element memory and sift sequencer
// depends on hsc_pkg, hsc_cmd_if, hsc_rsp_if
//
// usage:
//   cmd channel carries mode, value, index; rsp carries one result for sort
//   and read commands, none for loads or unused mode codes.
//   loads are taken one per cycle while idle; a read result is registered through
//   the S_READ state into the output register, and the next sort or read is taken
//   once that result is transferred.
//   a sort walks the element memory (one read and one write port): each sift
//   visit reads the node and both children (states S_VROOT, S_VLEFT, S_VRIGHT,
//   S_VDEC) and a swap writes two entries (S_SWAPA, S_ROOTW); cmd ready stays
//   low for the whole sort.
//   reset clears the count and totals; memory contents are not cleared.
//   when rsp is stalled, the result stays in its output register and no
//   new sort or read is taken until it is transferred; loads continue.
`default_nettype none
module heap_sort_with_counts (
    input wire logic clk,
    input wire logic rst_n,
    hsc_cmd_if.sink cmd,
    hsc_rsp_if.source rsp
);
    localparam int AW = hsc_pkg::AW;
    localparam int CW = hsc_pkg::CW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_BUILD = 4'd2;
    localparam logic [3:0] S_VROOT = 4'd3;
    localparam logic [3:0] S_VLEFT = 4'd4;
    localparam logic [3:0] S_VRIGHT = 4'd5;
    localparam logic [3:0] S_VDEC = 4'd6;
    localparam logic [3:0] S_SWAPA = 4'd7;
    localparam logic [3:0] S_TAIL = 4'd8;
    localparam logic [3:0] S_TAILR = 4'd9;
    localparam logic [3:0] S_REPORT = 4'd10;
    localparam logic [3:0] S_ROOTW = 4'd11;
    localparam logic [3:0] S_TAILV = 4'd12;
    localparam logic [3:0] S_TAILW = 4'd13;

    logic signed [31:0] mem [hsc_pkg::MAX_ELEMENTS];
    logic [AW-1:0] raddr;
    logic signed [31:0] rdata;
    logic we;
    logic [AW-1:0] waddr;
    logic signed [31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

    logic [3:0] state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [15:0] cmp_reg, cmp_next;
    logic [16:0] copy_reg, copy_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] len_reg, len_next;
    logic [CW:0] root_reg, root_next;
    logic [CW:0] top_reg, top_next;
    logic signed [31:0] rootv_reg, rootv_next;
    logic signed [31:0] topv_reg, topv_next;
    logic build_reg, build_next;
    logic ovalid_reg, ovalid_next;
    hsc_pkg::rsp_t out_reg, out_next;

    logic [CW+1:0] lchild, rchild;
    logic [16:0] cmp_sum;
    logic [17:0] copy_sum;
    logic free;

    assign lchild = {root_reg, 1'b1};
    assign rchild = {root_reg, 1'b0} + (CW+2)'(2);
    assign cmp_sum = {1'b0, cmp_reg} + 17'd2;
    assign copy_sum = {1'b0, copy_reg} + 18'(hsc_pkg::COPIES_PER_SWAP);
    assign free = !ovalid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cmp_next = cmp_reg;
        copy_next = copy_reg;
        i_next = i_reg;
        len_next = len_reg;
        root_next = root_reg;
        top_next = top_reg;
        rootv_next = rootv_reg;
        topv_next = topv_reg;
        build_next = build_reg;
        ovalid_next = ovalid_reg && !rsp.ready;
        out_next = out_reg;
        cmd.ready = 1'b0;
        raddr = root_reg[AW-1:0];
        we = 1'b0;
        waddr = count_reg[AW-1:0];
        wdata = cmd.data.value;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = (cmd.data.mode == hsc_pkg::MODE_LOAD) || free;
                raddr = cmd.data.index[AW-1:0];
                if (cmd.valid && cmd.ready)
                begin
                    case (cmd.data.mode)
                        hsc_pkg::MODE_LOAD:
                        begin
                            if (count_reg < CW'(hsc_pkg::MAX_ELEMENTS))
                            begin
                                we = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        hsc_pkg::MODE_SORT:
                        begin
                            cmp_next = '0;
                            copy_next = '0;
                            len_next = count_reg;
                            i_next = count_reg >> 1;
                            build_next = 1'b1;
                            state_next = S_BUILD;
                        end
                        hsc_pkg::MODE_READ:
                        begin
                            i_next = CW'(cmd.data.index);
                            state_next = S_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                ovalid_next = 1'b1;
                out_next.result_kind = hsc_pkg::KIND_ELEMENT;
                out_next.in_range = i_reg < count_reg;
                out_next.element = (i_reg < count_reg) ? rdata : '0;
                out_next.comparisons = '0;
                out_next.copies = '0;
                out_next.length = 11'(count_reg);
                state_next = S_IDLE;
            end
            S_BUILD:
            begin
                if (i_reg == '0)
                begin
                    build_next = 1'b0;
                    i_next = len_reg;
                    state_next = S_TAIL;
                end
                else
                begin
                    root_next = (CW+1)'(i_reg - CW'(1));
                    i_next = i_reg - CW'(1);
                    state_next = S_VROOT;
                end
            end
            S_VROOT:
            begin
                raddr = root_reg[AW-1:0];
                cmp_next = cmp_sum[16] ? 16'(hsc_pkg::CMP_MAX) : cmp_sum[15:0];
                top_next = root_reg;
                state_next = S_VLEFT;
            end
            S_VLEFT:
            begin
                rootv_next = rdata;
                topv_next = rdata;
                raddr = lchild[AW-1:0];
                state_next = S_VRIGHT;
            end
            S_VRIGHT:
            begin
                if (lchild < (CW+2)'(len_reg) && rdata > topv_reg)
                begin
                    topv_next = rdata;
                    top_next = lchild[CW:0];
                end
                raddr = rchild[AW-1:0];
                state_next = S_VDEC;
            end
            S_VDEC:
            begin
                if (rchild < (CW+2)'(len_reg) && rdata > topv_reg)
                begin
                    topv_next = rdata;
                    top_next = rchild[CW:0];
                    state_next = S_SWAPA;
                end
                else if (top_reg != root_reg)
                begin
                    state_next = S_SWAPA;
                end
                else
                begin
                    state_next = build_reg ? S_BUILD : S_TAIL;
                end
            end
            S_SWAPA:
            begin
                we = 1'b1;
                waddr = root_reg[AW-1:0];
                wdata = topv_reg;
                copy_next = copy_sum[17] ? 17'(hsc_pkg::COPY_MAX) : copy_sum[16:0];
                state_next = S_ROOTW;
            end
            S_ROOTW:
            begin
                we = 1'b1;
                waddr = top_reg[AW-1:0];
                wdata = rootv_reg;
                root_next = top_reg;
                state_next = S_VROOT;
            end
            S_TAIL:
            begin
                if (i_reg <= CW'(1))
                begin
                    state_next = S_REPORT;
                end
                else
                begin
                    raddr = '0;
                    state_next = S_TAILR;
                end
            end
            S_TAILR:
            begin
                raddr = AW'(i_reg - CW'(1));
                rootv_next = rdata;
                len_next = i_reg - CW'(1);
                i_next = i_reg - CW'(1);
                root_next = '0;
                top_next = (CW+1)'(i_reg - CW'(1));
                state_next = S_TAILV;
            end
            // swap of root and tail, then sift from the root
            S_TAILV:
            begin
                we = 1'b1;
                waddr = '0;
                wdata = rdata;
                copy_next = copy_sum[17] ? 17'(hsc_pkg::COPY_MAX) : copy_sum[16:0];
                state_next = S_TAILW;
            end
            S_TAILW:
            begin
                we = 1'b1;
                waddr = top_reg[AW-1:0];
                wdata = rootv_reg;
                state_next = S_VROOT;
            end
            S_REPORT:
            begin
                if (free)
                begin
                    ovalid_next = 1'b1;
                    out_next.result_kind = hsc_pkg::KIND_REPORT;
                    out_next.element = '0;
                    out_next.in_range = 1'b0;
                    out_next.comparisons = cmp_reg;
                    out_next.copies = copy_reg;
                    out_next.length = 11'(count_reg);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            cmp_reg <= '0;
            copy_reg <= '0;
            ovalid_reg <= 1'b0;
            build_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cmp_reg <= cmp_next;
            copy_reg <= copy_next;
            ovalid_reg <= ovalid_next;
            build_reg <= build_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next;
        len_reg <= len_next;
        root_reg <= root_next;
        top_reg <= top_next;
        rootv_reg <= rootv_next;
        topv_reg <= topv_next;
        out_reg <= out_next;
    end

    assign rsp.valid = ovalid_reg;
    assign rsp.data = out_reg;

`ifndef SYNTHESIS
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(hsc_pkg::MAX_ELEMENTS))
        else $error("count overflow");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !cmd.ready)
        else $error("ready while sorting");
    a_count_sort: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && state_reg != S_READ |=> $stable(count_reg))
        else $error("count changed during sort");
`endif
endmodule
`default_nettype wire

/* verif/hsc_checker.sv */
// checker for the heap sort block: watches both channels, predicts results, compares
// depends on hsc_pkg, hsc_cmd_if, hsc_rsp_if
`timescale 1ns / 1ps
module hsc_checker (
    input wire logic clk,
    input wire logic rst_n,
    hsc_cmd_if cmd,
    hsc_rsp_if rsp,
    output int fail_count,
    output int pending,
    output int sorts_seen,
    output int reads_seen
);
    logic signed [31:0] store [hsc_pkg::MAX_ELEMENTS];
    int unsigned count;
    int unsigned cmp_total;
    int unsigned copy_total;
    hsc_pkg::rsp_t expected_q [$];

    function automatic void bump_cmp();
        cmp_total = cmp_total + 2;
        if (cmp_total > hsc_pkg::CMP_MAX)
            cmp_total = hsc_pkg::CMP_MAX;
    endfunction

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic signed [31:0] t;
        t = store[a];
        store[a] = store[b];
        store[b] = t;
        copy_total = copy_total + hsc_pkg::COPIES_PER_SWAP;
        if (copy_total > hsc_pkg::COPY_MAX)
            copy_total = hsc_pkg::COPY_MAX;
    endfunction

    function automatic void sift(int unsigned len, int unsigned root);
        int unsigned top;
        int unsigned l;
        int unsigned r;
        forever
        begin
            top = root;
            l = 2 * root + 1;
            r = 2 * root + 2;
            bump_cmp();
            if (l < len && store[l] > store[top])
                top = l;
            if (r < len && store[r] > store[top])
                top = r;
            if (top == root)
                return;
            swap_entries(root, top);
            root = top;
        end
    endfunction

    function automatic void sort_store();
        int unsigned i;
        cmp_total = 0;
        copy_total = 0;
        for (i = count / 2; i > 0; i--)
            sift(count, i - 1);
        for (i = count; i > 1; i--)
        begin
            swap_entries(0, i - 1);
            sift(i - 1, 0);
        end
    endfunction

    function automatic void predict(hsc_pkg::cmd_t c);
        hsc_pkg::rsp_t e;
        e = '0;
        e.length = count[10:0];
        case (c.mode)
            hsc_pkg::MODE_LOAD:
            begin
                if (count < hsc_pkg::MAX_ELEMENTS)
                begin
                    store[count] = c.value;
                    count++;
                end
            end
            hsc_pkg::MODE_SORT:
            begin
                sort_store();
                e.result_kind = hsc_pkg::KIND_REPORT;
                e.comparisons = cmp_total[15:0];
                e.copies = copy_total[16:0];
                expected_q.insert(expected_q.size(), e);
            end
            hsc_pkg::MODE_READ:
            begin
                e.result_kind = hsc_pkg::KIND_ELEMENT;
                if (c.index < count)
                begin
                    e.element = store[c.index];
                    e.in_range = 1'b1;
                end
                expected_q.insert(expected_q.size(), e);
            end
            default:
            begin
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hsc_pkg::rsp_t e;
        if (!rst_n)
        begin
            count = 0;
            cmp_total = 0;
            copy_total = 0;
            expected_q.delete();
            fail_count <= 0;
            sorts_seen <= 0;
            reads_seen <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", rsp.data);
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (rsp.data !== e)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("result mismatch: expected %p actual %p", e, rsp.data);
                    end
                    if (e.result_kind == hsc_pkg::KIND_REPORT)
                        sorts_seen <= sorts_seen + 1;
                    else
                        reads_seen <= reads_seen + 1;
                end
            end
            if (cmd.valid && cmd.ready)
                predict(cmd.data);
        end
        pending = expected_q.size();
    end
endmodule

/* verif/tb_top.sv */
// testbench top for heap_sort_with_counts: clock, reset, stimulus and verdict
// depends on hsc_pkg, the channel interfaces, hsc_checker and the block
`timescale 1ns / 1ps
module tb_top;
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int fail_count;
    int pending;
    int sorts_seen;
    int reads_seen;
    int idle_cycles = 0;
    int sent = 0;
    int loaded = 0;
    int stall_phase = 0;
    int stall_mode = 0;

    hsc_cmd_if cmd ();
    hsc_rsp_if rsp ();

    heap_sort_with_counts i_dut (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));

    hsc_checker i_checker (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp), .fail_count(fail_count),
        .pending(pending), .sorts_seen(sorts_seen), .reads_seen(reads_seen)
    );

    always #2 clk = ~clk;

    initial
    begin
        cmd.valid = 1'b0;
        cmd.data = '0;
        rsp.ready = 1'b0;
    end

    // receiver stall pattern, switching at random among four styles
    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 300 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ($urandom_range(0, 3) != 0);
            2: rsp.ready <= (stall_phase % 7 < 3);
            default: rsp.ready <= ($urandom_range(0, 9) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 400000)
        begin
            $display("watchdog expired");
            $display("heap_sort_with_counts regression: fail");
            $finish;
        end
    end

    // holds valid until the transfer, then returns at the next edge
    task automatic send(logic [1:0] mode, logic signed [31:0] value, logic [9:0] index);
        hsc_pkg::cmd_t c;
        c.mode = mode;
        c.value = value;
        c.index = index;
        cmd.valid <= 1'b1;
        cmd.data <= c;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        sent++;
        if (mode == hsc_pkg::MODE_LOAD)
            loaded++;
    endtask

    task automatic gap();
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
        if (n > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic load_random(int n);
        logic signed [31:0] v;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(0, 3))
                0: v = $signed($urandom_range(0, 15)) - 8;
                1: v = ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
                default: v = $urandom;
            endcase
            send(hsc_pkg::MODE_LOAD, v, 10'($urandom));
            if ($urandom_range(0, 3) == 0)
                gap();
        end
    endtask

    task automatic read_some(int n);
        logic [9:0] idx;
        for (int i = 0; i < n; i++)
        begin
            idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
            send(hsc_pkg::MODE_READ, $urandom, idx);
            if ($urandom_range(0, 3) == 0)
                gap();
        end
    endtask

    initial
    begin
        int set_size;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty sort, reads of empty store, extremes, unused mode
        send(hsc_pkg::MODE_SORT, 0, 0);
        send(hsc_pkg::MODE_READ, 0, 10'd0);
        send(hsc_pkg::MODE_READ, 0, 10'h3ff);
        send(hsc_pkg::MODE_LOAD, 32'sh7fffffff, 10'h3ff);
        send(hsc_pkg::MODE_SORT, 0, 0);
        send(hsc_pkg::MODE_LOAD, 32'sh80000000, 0);
        send(hsc_pkg::MODE_LOAD, 0, 0);
        send(hsc_pkg::MODE_LOAD, -1, 0);
        send(hsc_pkg::MODE_LOAD, 32'sh55555555, 0);
        send(hsc_pkg::MODE_LOAD, 32'shaaaaaaaa, 0);
        send(hsc_pkg::MODE_NONE, -1, 10'h3ff);
        send(hsc_pkg::MODE_SORT, 0, 0);
        for (int i = 0; i < 7; i++)
            send(hsc_pkg::MODE_READ, 0, i[9:0]);
        send(hsc_pkg::MODE_SORT, 0, 0);
        gap();

        // random: short sets of loads, sort, reads; loads append across sorts
        while (sent < 950)
        begin
            set_size = $urandom_range(0, 12);
            load_random(set_size);
            if ($urandom_range(0, 9) == 0)
                send(hsc_pkg::MODE_NONE, $urandom, 10'($urandom));
            send(hsc_pkg::MODE_SORT, 0, 0);
            gap();
            read_some($urandom_range(2, 10));
            if (loaded > 40)
            begin
                // then fill past capacity once for one large sort
                break;
            end
        end
        load_random(hsc_pkg::MAX_ELEMENTS + 4 - loaded);
        send(hsc_pkg::MODE_SORT, 0, 0);
        read_some(20);
        send(hsc_pkg::MODE_READ, 0, 10'h3ff);
        send(hsc_pkg::MODE_LOAD, 32'sh12345678, 0);
        send(hsc_pkg::MODE_SORT, 0, 0);
        read_some(30);
        cmd.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("sent %0d commands, %0d loads; checked %0d sort reports and %0d reads",
            sent, loaded, sorts_seen, reads_seen);
        $display("store filled past capacity, extra loads dropped, full-size sort checked");
        if (fail_count == 0)
            $display("heap_sort_with_counts regression: pass");
        else
            $display("heap_sort_with_counts regression: fail");
        $finish;
    end
endmodule

/* filelist.f */
hdl/hsc_pkg.sv
hdl/hsc_cmd_if.sv
hdl/hsc_rsp_if.sv
hdl/heap_sort_with_counts.sv
verif/hsc_checker.sv
verif/tb_top.sv
